// File: hdl/erfa_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the erf/erfc pipeline.
package erfa_pkg;

    localparam int QB = 30;
    localparam int QW = 31;
    localparam logic [QW-1:0] ONE = 31'h4000_0000;
    localparam logic [63:0] HALF = 64'h2000_0000;

    localparam int X_FRAC_BITS_DEF   = 12;
    localparam int OUT_FRAC_BITS_DEF = 15;

    // Rational approximation coefficients, Q.30 rounded to nearest
    localparam logic [QW-1:0] CA1 =
        31'(((64'd254829592 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [QW-1:0] CA2 =
        31'(((64'd284496736 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [QW-1:0] CA3 =
        31'(((64'd1421413741 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [QW-1:0] CA4 =
        31'(((64'd1453152027 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [QW-1:0] CA5 =
        31'(((64'd1061405429 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [28:0] CP =
        29'(((64'd3275911 << 30) + 64'd5000000) / 64'd10000000);
    localparam logic [29:0] CLN2 =
        30'(((64'd6931471806 << 30) + 64'd5000000000) / 64'd10000000000);

    // exp(-y) underflows to zero once y reaches 63 ln2
    localparam logic [35:0] Y_LIMIT = 36'(64'd63 * 64'(CLN2));

    // Datapath widths
    localparam int DW  = 38;   // 1 + p*x
    localparam int YW  = 46;   // x*x in Q.30
    localparam int KW  = 6;    // ln2 multiple
    localparam int AW  = 34;   // signed Horner accumulator

    localparam logic signed [AW-1:0] COEF_ADD [5] = '{
        -$signed(34'(CA4)), $signed(34'(CA3)), -$signed(34'(CA2)),
        $signed(34'(CA1)), 34'sd0
    };

    // floor(2^32 / n) for n = 1..12, index n-1
    localparam logic [32:0] RECIP [12] = '{
        33'(64'h1_0000_0000 / 64'd1),  33'(64'h1_0000_0000 / 64'd2),
        33'(64'h1_0000_0000 / 64'd3),  33'(64'h1_0000_0000 / 64'd4),
        33'(64'h1_0000_0000 / 64'd5),  33'(64'h1_0000_0000 / 64'd6),
        33'(64'h1_0000_0000 / 64'd7),  33'(64'h1_0000_0000 / 64'd8),
        33'(64'h1_0000_0000 / 64'd9),  33'(64'h1_0000_0000 / 64'd10),
        33'(64'h1_0000_0000 / 64'd11), 33'(64'h1_0000_0000 / 64'd12)
    };

    localparam int EXP_STEPS = 12;
    localparam int DIV_LAT   = 31;
    localparam int POLY_LAT  = 10;
    localparam int EXP_LAT   = KW + 3 * EXP_STEPS + 1;
    localparam int ALIGN_LAT = EXP_LAT - DIV_LAT - POLY_LAT;
    localparam int TOT_LAT   = EXP_LAT + 4;

endpackage

// File: hdl/erfa_dly.sv
`timescale 1ns / 1ps
// Fixed-length delay line for aligning payload between pipeline branches.
module erfa_dly #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_data;
        for (int i = 1; i < DEPTH; i++) begin
            r_tap[i] <= r_tap[i-1];
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// File: hdl/erfa_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: t = round(2^60 / d), one quotient bit per stage.
module erfa_div (
    input  logic                    i_clk,
    input  logic [erfa_pkg::DW-1:0] i_d,
    output logic [erfa_pkg::QW-1:0] o_t
);

    localparam int DW = erfa_pkg::DW;
    localparam int NS = erfa_pkg::DIV_LAT;

    logic [DW-1:0] r_rem [NS];
    logic [DW-1:0] r_d   [NS];
    logic [NS-1:0] r_q   [NS];

    for (genvar j = 0; j < NS; j++) begin : g_st
        logic [DW-1:0] c_rem;
        logic [DW-1:0] c_d;
        logic [NS-1:0] c_q;
        logic [DW:0]   trial;
        logic          ge;

        if (j == 0) begin : g_in
            // dividend is 2^60 + d/2; its top bits are 2^29 + d>>32
            assign c_rem = DW'(32'h2000_0000) + DW'(i_d >> 32);
            assign c_d   = i_d;
            assign c_q   = '0;
        end else begin : g_mid
            assign c_rem = r_rem[j-1];
            assign c_d   = r_d[j-1];
            assign c_q   = r_q[j-1];
        end

        // low dividend bit 30-j is d bit 31-j
        assign trial = {c_rem, c_d[31-j]};
        assign ge    = (trial >= {1'b0, c_d});

        always_ff @(posedge i_clk) begin
            r_rem[j] <= ge ? DW'(trial - {1'b0, c_d}) : DW'(trial);
            r_d[j]   <= c_d;
            r_q[j]   <= {c_q[NS-2:0], ge};
        end
    end

    assign o_t = r_q[NS-1];

endmodule

// File: hdl/erfa_poly.sv
`timescale 1ns / 1ps
// Five-step Horner polynomial in t, two register stages per step, clamped to 0..1.
module erfa_poly (
    input  logic                    i_clk,
    input  logic [erfa_pkg::QW-1:0] i_t,
    output logic [erfa_pkg::QW-1:0] o_poly
);

    localparam int AW = erfa_pkg::AW;
    localparam int QW = erfa_pkg::QW;

    logic [62:0]           r_prod [5];
    logic                  r_neg  [5];
    logic [QW-1:0]         r_ta   [5];
    logic signed [AW-1:0]  r_acc  [5];
    logic [QW-1:0]         r_tb   [5];

    for (genvar k = 0; k < 5; k++) begin : g_step
        logic signed [AW-1:0] c_acc;
        logic [QW-1:0]        c_t;
        logic [AW-2:0]        mag;
        logic [62:0]          rnd;
        logic signed [AW-1:0] term;
        logic signed [AW-1:0] sum;
        logic signed [AW-1:0] res;

        if (k == 0) begin : g_in
            assign c_acc = $signed(AW'(erfa_pkg::CA5));
            assign c_t   = i_t;
        end else begin : g_mid
            assign c_acc = r_acc[k-1];
            assign c_t   = r_tb[k-1];
        end

        assign mag = c_acc[AW-1] ? (AW-1)'(-c_acc) : (AW-1)'(c_acc);

        always_ff @(posedge i_clk) begin
            r_prod[k] <= 63'(mag) * 63'(c_t);
            r_neg[k]  <= c_acc[AW-1];
            r_ta[k]   <= c_t;
        end

        // round the magnitude, restore the sign, add the next coefficient
        assign rnd  = (r_prod[k] + 63'(erfa_pkg::HALF)) >> erfa_pkg::QB;
        assign term = r_neg[k] ? -$signed(AW'(rnd)) : $signed(AW'(rnd));
        assign sum  = term + erfa_pkg::COEF_ADD[k];

        if (k == 4) begin : g_clamp
            always_comb begin
                if (sum < 0) begin
                    res = '0;
                end else if (sum > $signed(AW'(erfa_pkg::ONE))) begin
                    res = $signed(AW'(erfa_pkg::ONE));
                end else begin
                    res = sum;
                end
            end
        end else begin : g_pass
            assign res = sum;
        end

        always_ff @(posedge i_clk) begin
            r_acc[k] <= res;
            r_tb[k]  <= r_ta[k];
        end
    end

    assign o_poly = QW'(r_acc[4]);

endmodule

// File: hdl/erfa_exp.sv
`timescale 1ns / 1ps
// exp(-y): ln2 range reduction, twelve-step series iteration, power-of-two scaling.
module erfa_exp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic                    i_mode,
    input  logic [erfa_pkg::YW-1:0] i_y,
    output logic                    o_vld,
    output logic                    o_mode,
    output logic [erfa_pkg::QW-1:0] o_e
);

    localparam int KW = erfa_pkg::KW;
    localparam int QW = erfa_pkg::QW;
    localparam int NS = erfa_pkg::EXP_STEPS;

    typedef struct packed {
        logic [KW-1:0] k;
        logic [29:0]   r;
        logic          zero;
        logic          mode;
    } t_side;

    // range reduction: k = y / ln2, one bit per stage
    logic [35:0]   r_krem  [KW];
    logic [KW-1:0] r_kq    [KW];
    logic          r_kzero [KW];
    logic          r_kmode [KW];
    logic [KW-1:0] r_kvld;

    for (genvar j = 0; j < KW; j++) begin : g_kdiv
        logic [35:0]   c_rem;
        logic [KW-1:0] c_q;
        logic          c_zero;
        logic          c_mode;
        logic          c_vld;
        logic [35:0]   cmp;
        logic          ge;

        if (j == 0) begin : g_in
            assign c_rem  = i_y[35:0];
            assign c_q    = '0;
            assign c_zero = (i_y >= erfa_pkg::YW'(erfa_pkg::Y_LIMIT));
            assign c_mode = i_mode;
            assign c_vld  = i_vld;
        end else begin : g_mid
            assign c_rem  = r_krem[j-1];
            assign c_q    = r_kq[j-1];
            assign c_zero = r_kzero[j-1];
            assign c_mode = r_kmode[j-1];
            assign c_vld  = r_kvld[j-1];
        end

        assign cmp = 36'(erfa_pkg::CLN2) << (KW - 1 - j);
        assign ge  = (c_rem >= cmp);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_kvld[j] <= 1'b0;
            end else begin
                r_kvld[j] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_krem[j]  <= ge ? c_rem - cmp : c_rem;
            r_kq[j]    <= {c_q[KW-2:0], ge};
            r_kzero[j] <= c_zero;
            r_kmode[j] <= c_mode;
        end
    end

    // series iteration s = 1 - round(r*s/n), n = 12 down to 1
    logic [60:0]   r_ap   [NS];
    t_side         r_asd  [NS];
    logic [NS-1:0] r_avld;
    logic [QW-1:0] r_bv   [NS];
    logic [QW-1:0] r_bq   [NS];
    t_side         r_bsd  [NS];
    logic [NS-1:0] r_bvld;
    logic [QW-1:0] r_cs   [NS];
    t_side         r_csd  [NS];
    logic [NS-1:0] r_cvld;

    for (genvar i = 0; i < NS; i++) begin : g_iter
        localparam int N = NS - i;
        logic [QW-1:0] c_s;
        t_side         c_sd;
        logic          c_vld;
        logic [60:0]   biased;
        logic [QW-1:0] v;
        logic [63:0]   qprod;
        logic [34:0]   rem;
        logic [QW-1:0] q;

        if (i == 0) begin : g_in
            assign c_s     = erfa_pkg::ONE;
            assign c_sd.k  = r_kq[KW-1];
            assign c_sd.r  = r_krem[KW-1][29:0];
            assign c_sd.zero = r_kzero[KW-1];
            assign c_sd.mode = r_kmode[KW-1];
            assign c_vld   = r_kvld[KW-1];
        end else begin : g_mid
            assign c_s   = r_cs[i-1];
            assign c_sd  = r_csd[i-1];
            assign c_vld = r_cvld[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_avld[i] <= 1'b0;
                r_bvld[i] <= 1'b0;
                r_cvld[i] <= 1'b0;
            end else begin
                r_avld[i] <= c_vld;
                r_bvld[i] <= r_avld[i];
                r_cvld[i] <= r_bvld[i];
            end
        end

        // floor(floor(P/n) + 2^29) >> 30 equals floor(((P + n*2^29) >> 30) / n)
        assign biased = r_ap[i] + (61'(N) << (erfa_pkg::QB - 1));
        assign v      = QW'(biased >> erfa_pkg::QB);
        assign qprod  = 64'(v) * 64'(erfa_pkg::RECIP[N-1]);

        // reciprocal estimate is low by at most one
        assign rem = 35'(r_bv[i]) - 35'(r_bq[i]) * 35'(N);
        assign q   = (rem >= 35'(N)) ? r_bq[i] + QW'(1) : r_bq[i];

        always_ff @(posedge i_clk) begin
            r_ap[i]  <= 61'(c_sd.r) * 61'(c_s);
            r_asd[i] <= c_sd;
            r_bv[i]  <= v;
            r_bq[i]  <= QW'(qprod >> 32);
            r_bsd[i] <= r_asd[i];
            r_cs[i]  <= erfa_pkg::ONE - q;
            r_csd[i] <= r_bsd[i];
        end
    end

    // scale by 2^-k with rounding
    t_side         f_sd;
    logic [QW-1:0] f_s;
    logic [KW-1:0] km1;
    logic [QW-1:0] sh;
    logic [QW-1:0] sh1;
    logic          rbit;
    logic [QW-1:0] r_e;
    logic          r_emode;
    logic          r_evld;

    assign f_sd = r_csd[NS-1];
    assign f_s  = r_cs[NS-1];
    assign km1  = f_sd.k - KW'(1);
    assign sh   = f_s >> f_sd.k;
    assign sh1  = f_s >> km1;
    assign rbit = (f_sd.k != '0) & sh1[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evld <= 1'b0;
        end else begin
            r_evld <= r_cvld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= f_sd.zero ? '0 : sh + QW'(rbit);
        r_emode <= f_sd.mode;
    end

    assign o_vld  = r_evld;
    assign o_mode = r_emode;
    assign o_e    = r_e;

endmodule

// File: hdl/erfc_erf_approximation.sv
`timescale 1ns / 1ps
// Top level: erfc(x) or erf(x) by the five-term rational approximation, fully pipelined.
//
// Takes an unsigned Q4.12 argument and a mode bit (0 erfc, 1 erf) on any cycle that
// start is high; busy is low except in reset, so one argument enters every clock.
// Each result appears for one cycle with o_strobe high, unsigned Q1.15 clamped to
// 0..1. The receiver cannot stall the block; results leave in the order their
// arguments came. The pipeline depth is set by the exp(-x^2) branch: 6 range-reduction
// stages, 12 series steps of 3 stages each and a scaling stage, plus 2 input and 2
// output stages; the 31-stage reciprocal divider and the 10-stage polynomial run
// beside it.
module erfc_erf_approximation #(
    parameter int X_FRAC_BITS   = erfa_pkg::X_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = erfa_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [15:0] i_x_value,
    output logic        o_strobe,
    output logic [15:0] o_func_value
);

    localparam int QW     = erfa_pkg::QW;
    localparam int DW     = erfa_pkg::DW;
    localparam int YW     = erfa_pkg::YW;
    localparam int Y_LSH  = (2 * X_FRAC_BITS < 30) ? 30 - 2 * X_FRAC_BITS : 0;
    localparam int Y_RSH  = (2 * X_FRAC_BITS >= 30) ? 2 * X_FRAC_BITS - 30 : 0;
    localparam int Y_RBIT = (Y_RSH == 0) ? 0 : Y_RSH - 1;
    localparam int OSH    = erfa_pkg::QB - OUT_FRAC_BITS;
    localparam logic [QW-1:0] ONE_OUT = QW'(1) << OUT_FRAC_BITS;
    localparam logic [QW-1:0] OUT_MAX = (ONE_OUT > QW'(16'hFFFF)) ? QW'(16'hFFFF) : ONE_OUT;

    logic accept;
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // stage 1: products p*x and x*x
    logic        r_s1_vld;
    logic        r_s1_mode;
    logic [44:0] r_s1_px;
    logic [31:0] r_s1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mode <= i_mode;
        r_s1_px   <= 45'(erfa_pkg::CP) * 45'(i_x_value);
        r_s1_y    <= 32'(i_x_value) * 32'(i_x_value);
    end

    // stage 2: bring both to Q.30
    logic [44:0]   px;
    logic [YW-1:0] y_sh;
    logic          y_rb;
    logic          r_s2_vld;
    logic          r_s2_mode;
    logic [DW-1:0] r_s2_d;
    logic [YW-1:0] r_s2_y;

    assign px   = (r_s1_px >> X_FRAC_BITS) + 45'(r_s1_px[X_FRAC_BITS-1]);
    assign y_sh = (YW'(r_s1_y) << Y_LSH) >> Y_RSH;
    assign y_rb = (Y_RSH != 0) & r_s1_y[Y_RBIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mode <= r_s1_mode;
        r_s2_d    <= DW'(erfa_pkg::ONE) + DW'(px);
        r_s2_y    <= y_sh + YW'(y_rb);
    end

    // rational part
    logic [QW-1:0] t_val;
    logic [QW-1:0] poly;
    logic [QW-1:0] poly_al;

    erfa_div u_div (
        .i_clk (i_clk),
        .i_d   (r_s2_d),
        .o_t   (t_val)
    );

    erfa_poly u_poly (
        .i_clk  (i_clk),
        .i_t    (t_val),
        .o_poly (poly)
    );

    erfa_dly #(
        .WIDTH (QW),
        .DEPTH (erfa_pkg::ALIGN_LAT)
    ) u_align (
        .i_clk  (i_clk),
        .i_data (poly),
        .o_data (poly_al)
    );

    // exponential part, carries valid and mode
    logic          e_vld;
    logic          e_mode;
    logic [QW-1:0] e_val;

    erfa_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_vld),
        .i_mode  (r_s2_mode),
        .i_y     (r_s2_y),
        .o_vld   (e_vld),
        .o_mode  (e_mode),
        .o_e     (e_val)
    );

    // combine
    logic        r_f_vld;
    logic        r_f_mode;
    logic [61:0] r_f_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_mode <= e_mode;
        r_f_prod <= 62'(poly_al) * 62'(e_val);
    end

    logic [31:0]   erfc_raw;
    logic [QW-1:0] erfc_c;
    logic [QW-1:0] v_sel;
    logic [QW-1:0] v_rnd;
    logic [15:0]   n_func;

    assign erfc_raw = 32'((r_f_prod + 62'(erfa_pkg::HALF)) >> erfa_pkg::QB);
    assign erfc_c   = (erfc_raw > 32'(erfa_pkg::ONE)) ? erfa_pkg::ONE : QW'(erfc_raw);
    assign v_sel    = r_f_mode ? erfa_pkg::ONE - erfc_c : erfc_c;
    assign v_rnd    = (v_sel >> OSH) + QW'(v_sel[OSH-1]);
    assign n_func   = (v_rnd > OUT_MAX) ? 16'(OUT_MAX) : 16'(v_rnd);

    logic        r_o_strobe;
    logic [15:0] r_o_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_func <= n_func;
    end

    assign o_strobe     = r_o_strobe;
    assign o_func_value = r_o_func;

`ifndef SYNTHESIS
    // every beat taken comes out as a result, and nothing else does
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, erfa_pkg::TOT_LAT))
        else $error("result strobe without an accepted beat");

    a_no_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(accept, erfa_pkg::TOT_LAT) |-> o_strobe)
        else $error("accepted beat produced no result");

    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_func_value <= 16'(OUT_MAX)))
        else $error("result above one");

    // erfc(0) comes out exactly one
    a_erfc_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(accept && (i_x_value == 16'd0) && !i_mode, erfa_pkg::TOT_LAT)
        |-> (o_func_value == 16'(OUT_MAX)))
        else $error("erfc(0) is not one");

    a_erf_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(accept && (i_x_value == 16'd0) && i_mode, erfa_pkg::TOT_LAT)
        |-> (o_func_value == 16'd0))
        else $error("erf(0) is not zero");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the erf/erfc rational approximation pipeline.

class erf_scoreboard;
    logic [15:0] expected_q[$];
    int          n_fail;
    int          n_checked;

    function new();
        n_fail = 0;
        n_checked = 0;
    endfunction

    // Round right shift as used throughout the fixed-point datapath.
    static function longint unsigned rshr(longint unsigned v, int n);
        if (n == 0) return v;
        if (n >= 64) return 0;
        return (v >> n) + ((v >> (n - 1)) & 1);
    endfunction

    static function longint mul30(longint a, longint unsigned t);
        longint unsigned m;
        longint unsigned r;
        m = (a < 0) ? longint'(-a) : a;
        r = (m * t + 64'h2000_0000) >> 30;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    static function longint unsigned exp_neg_sq(longint unsigned xr);
        longint unsigned y30;
        longint unsigned k;
        longint unsigned r;
        longint unsigned s;
        // bring x*x to Q.30: round to nearest from a finer scale, shift up from a coarser one
        if (2 * erfa_pkg::X_FRAC_BITS_DEF >= 30)
            y30 = rshr(xr * xr, 2 * erfa_pkg::X_FRAC_BITS_DEF - 30);
        else
            y30 = (xr * xr) << (30 - 2 * erfa_pkg::X_FRAC_BITS_DEF);
        k = y30 / 64'(erfa_pkg::CLN2);
        r = y30 - k * 64'(erfa_pkg::CLN2);
        s = 64'(erfa_pkg::ONE);
        for (int n = 12; n >= 1; n--)
            s = 64'(erfa_pkg::ONE) - (((r * s) / n + 64'h2000_0000) >> 30);
        if (k >= 63) return 0;
        return rshr(s, int'(k));
    endfunction

    static function logic [15:0] erf_value(logic mode, logic [15:0] x);
        longint unsigned one_q;
        longint unsigned px;
        longint unsigned d;
        longint unsigned t;
        longint unsigned e;
        longint unsigned ec;
        longint unsigned v;
        longint acc;
        one_q = 64'(erfa_pkg::ONE);
        px = rshr(64'(erfa_pkg::CP) * x, erfa_pkg::X_FRAC_BITS_DEF);
        d = one_q + px;
        t = ((64'd1 << 60) + (d >> 1)) / d;
        acc = longint'(erfa_pkg::CA5);
        acc = mul30(acc, t) - longint'(erfa_pkg::CA4);
        acc = mul30(acc, t) + longint'(erfa_pkg::CA3);
        acc = mul30(acc, t) - longint'(erfa_pkg::CA2);
        acc = mul30(acc, t) + longint'(erfa_pkg::CA1);
        acc = mul30(acc, t);
        if (acc < 0) acc = 0;
        if (acc > longint'(one_q)) acc = one_q;
        e = exp_neg_sq(x);
        ec = (longint'(acc) * e + 64'h2000_0000) >> 30;
        if (ec > one_q) ec = one_q;
        v = mode ? one_q - ec : ec;
        v = rshr(v, 30 - erfa_pkg::OUT_FRAC_BITS_DEF);
        if (v > (64'd1 << erfa_pkg::OUT_FRAC_BITS_DEF)) v = 64'd1 << erfa_pkg::OUT_FRAC_BITS_DEF;
        if (v > 64'hFFFF) v = 64'hFFFF;
        return v[15:0];
    endfunction

    function void note_arg(logic mode, logic [15:0] x);
        expected_q.push_back(erf_value(mode, x));
    endfunction

    function void check_value(logic [15:0] got);
        logic [15:0] want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result func_value=%0d", $time, got);
            n_fail++;
            return;
        end
        want = expected_q.pop_front();
        n_checked++;
        if (want !== got) begin
            $display("%0t: func_value mismatch expected=%0d actual=%0d", $time, want, got);
            n_fail++;
        end
    endfunction
endclass

module testbench;
    localparam int WATCHDOG = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_mode;
    logic [15:0] i_x_value;
    logic        o_strobe;
    logic [15:0] o_func_value;

    erf_scoreboard sb;
    int            idle_cycles;
    int            n_args;
    bit            stim_done;

    erfc_erf_approximation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_x_value(i_x_value),
        .o_strobe(o_strobe), .o_func_value(o_func_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sample accepted beats on both sides at the rising edge.
    always @(posedge i_clk) begin
        bit took;
        if (i_rst_n) begin
            took = 1'b0;
            if (start && !busy) begin
                sb.note_arg(i_mode, i_x_value);
                took = 1'b1;
            end
            if (o_strobe) begin
                sb.check_value(o_func_value);
                took = 1'b1;
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("erfc_erf_approximation verification failed");
                $finish;
            end
            idle_cycles <= took ? 0 : idle_cycles + 1;
        end
    end

    // Present one argument; gap cycles idle before it (0 keeps start high).
    task automatic send_arg(logic mode, logic [15:0] x, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_mode    <= mode;
        i_x_value <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        n_args++;
    endtask

    function automatic logic [15:0] rand_x();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 255));
            1: return 16'($urandom_range(0, 4095));
            2: return 16'($urandom_range(4096, 16383));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] directed[] = '{16'h0000, 16'h0001, 16'h0002, 16'h0800, 16'h1000,
                                    16'h2000, 16'h3000, 16'h4000, 16'h7FFF, 16'h8000,
                                    16'hFFFE, 16'hFFFF};
        sb = new();
        idle_cycles = 0;
        n_args = 0;
        stim_done = 0;
        start = 1'b0;
        i_mode = 1'b0;
        i_x_value = '0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            send_arg(1'b0, directed[i], 0);
            send_arg(1'b1, directed[i], 0);
        end
        for (int i = 0; i < 900; i++) begin
            // Long runs back to back, with bursts of random gaps.
            send_arg($urandom_range(0, 1), rand_x(),
                     ((i / 100) % 2 == 0) ? 0 : $urandom_range(0, 17));
        end
        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (3 * erfa_pkg::TOT_LAT) @(negedge i_clk);

        $display("Sent %0d arguments in both modes, directed extremes then random,",
                 n_args);
        $display("and checked %0d results against the fixed-point prediction.",
                 sb.n_checked);
        if (sb.n_fail == 0) begin
            $display("erfc_erf_approximation verification clean");
        end else begin
            $display("erfc_erf_approximation verification failed");
        end
        $finish;
    end
endmodule
